### rtl/lkr_pkg.sv
// ----------------------------------------------------------------------------
// lkr_pkg
// Shared types, sizes and codes of the LRU-K frame replacer.
// ----------------------------------------------------------------------------
package lkr_pkg;

   localparam int FRAMES     = 64;
   localparam int K_MAX      = 4;
   localparam int STAMP_BITS = 48;

   localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int LEN_W   = $clog2(K_MAX + 1);
   localparam int ROW_W   = LEN_W + K_MAX * STAMP_BITS;

   typedef enum logic [1:0] {
      MODE_RECORD = 2'd0,
      MODE_MARK   = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_EVICT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_PINNED    = 2'd2,
      ST_NO_VICTIM = 2'd3
   } status_type;

   localparam logic [1:0] CSR_HISTORY_DEPTH = 2'd0;
   localparam logic [1:0] CSR_FRAMES_IN_USE = 2'd1;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] frame;
      logic       make_evictable;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] victim_frame;
      logic [6:0] evictable_count;
   } rsp_type;

   typedef struct packed {
      logic latch_req;
      logic set_range;
      logic rec_write;
      logic mark;
      logic remove;
      logic scan_start;
      logic scan_read;
      logic evict_end;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       out_of_range;
      logic       scan_last;
      logic       out_free;
   } stat_type;

endpackage

### rtl/lkr_ram.sv
// ----------------------------------------------------------------------------
// lkr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/lkr_ctrl.sv
// ----------------------------------------------------------------------------
// lkr_ctrl
// Sequencer of the replacer: decodes each request and steps the datapath.
// ----------------------------------------------------------------------------
module lkr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lkr_pkg::stat_type stat,
   output lkr_pkg::cmd_type  cmd
);
   import lkr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_REC_RD, S_REC_WR, S_SCAN,
      S_DRAIN1, S_DRAIN2, S_EVICT, S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.out_of_range) begin
               cmd.set_range = 1'b1;
               state_in      = S_FINISH;
            end else begin
               unique case (mode_type'(stat.mode))
                  MODE_RECORD: state_in = S_REC_RD;
                  MODE_MARK: begin
                     cmd.mark = 1'b1;
                     state_in = S_FINISH;
                  end
                  MODE_REMOVE: begin
                     cmd.remove = 1'b1;
                     state_in   = S_FINISH;
                  end
                  default: begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               endcase
            end
         end
         S_REC_RD: state_in = S_REC_WR;
         S_REC_WR: begin
            cmd.rec_write = 1'b1;
            state_in      = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DRAIN1;
            end
         end
         S_DRAIN1: state_in = S_DRAIN2;
         S_DRAIN2: state_in = S_EVICT;
         S_EVICT: begin
            cmd.evict_end = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_scan_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |=> state_ff == S_SCAN)
      else $error("scan start did not enter the scan");
   a_drain_to_evict: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN1 |=> ##1 state_ff == S_EVICT)
      else $error("scan drain length broken");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd.latch_req |=> !req_ready)
      else $error("request taken while busy");
`endif

endmodule

### rtl/lkr_datapath.sv
// ----------------------------------------------------------------------------
// lkr_datapath
// Frame state, stamp history memory, eviction scan and result register.
// ----------------------------------------------------------------------------
module lkr_datapath (
   input  logic              clock,
   input  logic              reset,
   input  lkr_pkg::req_type  req,
   input  logic              csr_valid,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_data,
   input  lkr_pkg::cmd_type  cmd,
   output lkr_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lkr_pkg::rsp_type  rsp
);
   import lkr_pkg::*;

   logic [2:0]            depth_ff;
   logic [6:0]            fcount_ff;
   req_type               req_ff;
   logic [FRAMES-1:0]     tracked_ff, evict_ff, lenok_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   logic [6:0]            total_ff, total_in;
   logic [1:0]            status_ff;
   logic [FRAME_W-1:0]    victim_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [FRAME_W-1:0]    scan_ff, p0_idx_ff, a_idx_ff, best_idx_ff;
   logic                  p0_valid_ff, p0_cand_ff, a_valid_ff, have_ff;
   logic                  a_inf_ff, best_inf_ff;
   logic [STAMP_BITS-1:0] a_d_ff, a_old_ff, best_d_ff, best_old_ff;

   logic [FRAME_W-1:0]    fidx;
   logic [LEN_W-1:0]      k_eff;
   logic [31:0]           f_eff;
   logic [ROW_W-1:0]      rd_row, wr_row;
   logic [LEN_W-1:0]      rd_len, new_len;
   logic                  take;
   logic                  c_inf;
   logic [STAMP_BITS-1:0] c_d, c_old;

   assign fidx = FRAME_W'(req_ff.frame);

   always_comb begin
      if (depth_ff == 3'd0) begin
         k_eff = LEN_W'(1);
      end else if (32'(depth_ff) > 32'(K_MAX)) begin
         k_eff = LEN_W'(K_MAX);
      end else begin
         k_eff = LEN_W'(depth_ff);
      end
      if (fcount_ff == 7'd0) begin
         f_eff = 32'd1;
      end else if (32'(fcount_ff) > 32'(FRAMES)) begin
         f_eff = 32'(FRAMES);
      end else begin
         f_eff = 32'(fcount_ff);
      end
   end

   assign stat.mode         = req_ff.mode;
   assign stat.out_of_range = (mode_type'(req_ff.mode) != MODE_EVICT) &&
                              (32'(req_ff.frame) >= f_eff);
   assign stat.scan_last    = (scan_ff == FRAME_W'(FRAMES - 1));
   assign stat.out_free     = !rsp_valid_ff || rsp_ready;

   lkr_ram #(.WIDTH(ROW_W), .DEPTH(FRAMES)) u_hist (
      .clock  (clock),
      .wr_en  (cmd.rec_write),
      .wr_addr(fidx),
      .wr_data(wr_row),
      .rd_addr(cmd.scan_read ? scan_ff : fidx),
      .rd_data(rd_row)
   );

   always_comb begin
      logic [LEN_W:0] inc;
      rd_len = lenok_ff[cmd.rec_write ? fidx : p0_idx_ff] ?
               rd_row[ROW_W-1 -: LEN_W] : '0;
      inc    = {1'b0, rd_len} + 1'b1;
      new_len = (inc > {1'b0, k_eff}) ? k_eff : inc[LEN_W-1:0];
      wr_row = {new_len, rd_row[(K_MAX-1)*STAMP_BITS-1:0], stamp_ff};
      c_inf = rd_len < k_eff;
      c_d   = stamp_ff - rd_row[(32'(k_eff) - 1) * STAMP_BITS +: STAMP_BITS];
      c_old = (rd_len == '0) ? '0 :
              rd_row[(32'(rd_len) - 1) * STAMP_BITS +: STAMP_BITS];
      if (c_inf) begin
         c_d = '0;
      end
   end

   always_comb begin
      if (!have_ff) begin
         take = 1'b1;
      end else if (a_inf_ff != best_inf_ff) begin
         take = a_inf_ff;
      end else if (!a_inf_ff && (a_d_ff != best_d_ff)) begin
         take = a_d_ff > best_d_ff;
      end else begin
         take = a_old_ff < best_old_ff;
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.mark && (evict_ff[fidx] != req_ff.make_evictable)) begin
         if (req_ff.make_evictable) begin
            total_in = total_ff + 7'd1;
         end else if (total_ff != 7'd0) begin
            total_in = total_ff - 7'd1;
         end
      end
      if ((cmd.remove && tracked_ff[fidx] && evict_ff[fidx]) ||
          (cmd.evict_end && have_ff)) begin
         if (total_ff != 7'd0) begin
            total_in = total_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= 3'd2;
         fcount_ff    <= 7'd64;
         tracked_ff   <= '0;
         evict_ff     <= '0;
         lenok_ff     <= '0;
         stamp_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         p0_valid_ff  <= 1'b0;
         a_valid_ff   <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_HISTORY_DEPTH)) begin
            depth_ff <= csr_data[2:0];
         end
         if (csr_valid && (csr_index == CSR_FRAMES_IN_USE)) begin
            fcount_ff <= csr_data;
         end
         total_ff <= total_in;
         if (cmd.rec_write) begin
            tracked_ff[fidx] <= 1'b1;
            lenok_ff[fidx]   <= 1'b1;
            stamp_ff         <= stamp_ff + 1'b1;
         end
         if (cmd.mark) begin
            tracked_ff[fidx] <= 1'b1;
            evict_ff[fidx]   <= req_ff.make_evictable;
         end
         if (cmd.remove && tracked_ff[fidx] && evict_ff[fidx]) begin
            tracked_ff[fidx] <= 1'b0;
            evict_ff[fidx]   <= 1'b0;
            lenok_ff[fidx]   <= 1'b0;
         end
         if (cmd.evict_end && have_ff) begin
            tracked_ff[best_idx_ff] <= 1'b0;
            evict_ff[best_idx_ff]   <= 1'b0;
            lenok_ff[best_idx_ff]   <= 1'b0;
         end
         p0_valid_ff <= cmd.scan_read;
         a_valid_ff  <= p0_valid_ff && p0_cand_ff;
         if (cmd.scan_start) begin
            have_ff <= 1'b0;
         end else if (a_valid_ff && take) begin
            have_ff <= 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff    <= req;
         status_ff <= ST_OK;
         victim_ff <= '0;
      end
      if (cmd.set_range) begin
         status_ff <= ST_RANGE;
      end
      if (cmd.remove && tracked_ff[fidx] && !evict_ff[fidx]) begin
         status_ff <= ST_PINNED;
      end
      if (cmd.evict_end) begin
         if (have_ff) begin
            victim_ff <= best_idx_ff;
         end else begin
            status_ff <= ST_NO_VICTIM;
         end
      end
      if (cmd.scan_start) begin
         scan_ff <= '0;
      end else if (cmd.scan_read) begin
         scan_ff <= scan_ff + 1'b1;
      end
      p0_idx_ff  <= scan_ff;
      p0_cand_ff <= tracked_ff[scan_ff] && evict_ff[scan_ff];
      a_idx_ff   <= p0_idx_ff;
      a_inf_ff   <= c_inf;
      a_d_ff     <= c_d;
      a_old_ff   <= c_old;
      if (a_valid_ff && take) begin
         best_idx_ff <= a_idx_ff;
         best_inf_ff <= a_inf_ff;
         best_d_ff   <= a_d_ff;
         best_old_ff <= a_old_ff;
      end
      if (cmd.finish) begin
         rsp_ff.status          <= status_ff;
         rsp_ff.victim_frame    <= 6'(victim_ff);
         rsp_ff.evictable_count <= total_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) == $countones(evict_ff))
      else $error("evictable total out of step with marks");
   a_evict_tracked: assert property (@(posedge clock) disable iff (reset)
      (evict_ff & ~tracked_ff) == '0)
      else $error("evictable frame not tracked");
   a_stamp_on_record: assert property (@(posedge clock) disable iff (reset)
      cmd.rec_write |=> stamp_ff == $past(stamp_ff) + 1'b1)
      else $error("stamp did not advance on access");
`endif

endmodule

### rtl/lru_k_frame_replacer_top.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer_top
// LRU-K replacer over a fixed set of frames with a request/response interface.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req (mode, frame, make_evictable)
// rsp      out        rsp_valid, rsp_ready, rsp (status, victim_frame, count)
// csr      in         csr_valid, csr_ready, csr_index, csr_data
//
// One request is handled at a time. After decode, record access reads the
// frame's history row and writes it back, mark, remove and a rejected frame
// go straight to the result, and evict reads the history memory one frame per
// cycle. A new request can be accepted in the cycle after the result is loaded.
// A result waiting in the output register holds the following request in its
// last step. Reset clears all marks and counters.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lkr_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lkr_pkg::rsp_type rsp,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_data
);
   import lkr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   lkr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   lkr_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

endmodule
